@@ design/pli_pkg.sv @@
// Package for the piecewise linear interpolator: payload types, codes, constants.
// No dependencies.
package pli_pkg;
   localparam int MAX_POINTS_DEF  = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SETUP = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CLAMP_LO = 3'd1;
   localparam logic [2:0] ST_CLAMP_HI = 3'd2;
   localparam logic [2:0] ST_ZERO     = 3'd3;
   localparam logic [2:0] ST_VALID    = 3'd4;
   localparam logic [2:0] ST_INVALID  = 3'd5;

   typedef struct packed {
      logic [1:0]         command;
      logic [5:0]         point_index;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] y_result;
      logic [2:0]         status;
   } rsp_word_type;
endpackage

@@ design/pli_divider.sv @@
// Restoring divider for the interpolator: one quotient bit per cycle, capped quotient.
// Depends on nothing outside itself.
module pli_divider #(
   parameter int NUM_WIDTH = 128,
   parameter int DEN_WIDTH = 33,
   parameter int Q_WIDTH   = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numer,
   input  logic [DEN_WIDTH-1:0] denom,
   input  logic [Q_WIDTH-1:0]   cap,
   output logic                 done,
   output logic [Q_WIDTH-1:0]   quot
);
   localparam int CW = $clog2(NUM_WIDTH + 1);
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [DEN_WIDTH:0]   rem_ff, rem_in;
   logic [Q_WIDTH-1:0]   q_ff, q_in;
   logic                 over_ff, over_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DEN_WIDTH:0]   shifted;
   logic                 take;
   logic [Q_WIDTH:0]     qn;

   always_comb begin
      shifted = {rem_ff[DEN_WIDTH-1:0], num_ff[NUM_WIDTH-1]};
      take    = shifted >= {1'b0, denom};
      qn      = {q_ff, take};
      num_in = num_ff; rem_in = rem_ff; q_in = q_ff; over_in = over_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         num_in = numer; rem_in = '0; q_in = '0; over_in = 1'b0;
         cnt_in = CW'(NUM_WIDTH); busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_WIDTH-2:0], 1'b0};
         rem_in = take ? shifted - {1'b0, denom} : shifted;
         if (!over_ff) begin
            // quotient saturates once it passes the cap
            if (qn > {1'b0, cap}) begin
               q_in = cap; over_in = 1'b1;
            end else begin
               q_in = qn[Q_WIDTH-1:0];
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; q_ff <= q_in; over_ff <= over_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign quot = q_in;

`ifndef SYNTHESIS
   a_cap: assert property (@(posedge clock) disable iff (reset) busy_ff |-> q_ff <= cap)
      else $error("quotient above cap");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count zero while busy");
   a_done: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff || $past(start)) else $error("divider busy after done");
`endif
endmodule

@@ design/piecewise_linear_interpolator_unit.sv @@
// Top level of the piecewise linear interpolator: table memory, sequencer, compare/subtract
// datapath, a multiplier and the serial divider. Depends on pli_pkg, pli_divider.
//
//  channel  dir  handshake        payload
//  req      in   req_valid/stall  req_word_type
//  rsp      out  rsp_valid/stall  rsp_word_type
//  csr      in   csr_write        point_count (7 bits)
//
// Write: at most one table write. Setup: a reversal sweep when the table is descending,
// then the order check, all through the single memory read port. Query: a bracket
// search through the table, a multiply, then the serial divider.
// Reset is synchronous; the table is not cleared. req_stall is high while busy or
// while a result waits; rsp_word holds until taken.
module piecewise_linear_interpolator_unit #(
   parameter int MAX_POINTS  = pli_pkg::MAX_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pli_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pli_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write,
   input  logic [6:0]            csr_data
);
   import pli_pkg::*;

   localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int VW = VALUE_WIDTH_DEF;
   localparam int DW = VW + 1;           // differences
   localparam int PW = 2 * DW;           // product magnitude
   localparam int QW = VW + 2;
   localparam int NW = (AW + 1 > 7) ? AW + 1 : 7;
   localparam logic signed [DW+1:0] Y_MAX = $signed((DW+2)'({1'b0, {(VW-1){1'b1}}}));
   localparam logic signed [DW+1:0] Y_MIN = ~Y_MAX;

   localparam logic [4:0] S_IDLE = 5'd0,  S_DONE = 5'd1,  S_SU_RD = 5'd2,
                          S_SU_RA = 5'd3, S_SU_RB = 5'd4, S_SU_WA = 5'd5,
                          S_SU_WB = 5'd6, S_CK_RD = 5'd7, S_CK_W = 5'd8,
                          S_Q_RD = 5'd9,  S_Q_FIRST = 5'd10, S_Q_LAST = 5'd11,
                          S_Q_SCAN = 5'd12, S_Q_Y0 = 5'd13, S_Q_Y1 = 5'd14,
                          S_Q_MUL = 5'd15, S_Q_DIV = 5'd16, S_Q_FIN = 5'd17,
                          S_SU_XC = 5'd18, S_Q_WAIT = 5'd19;

   logic signed [VW-1:0] mem_x [MAX_POINTS];
   logic signed [VW-1:0] mem_y [MAX_POINTS];
   logic [AW-1:0]        raddr;
   logic signed [VW-1:0] rx_ff, ry_ff;
   logic                 we;
   logic [AW-1:0]        waddr;
   logic signed [VW-1:0] wx, wy;

   logic [4:0]           state_ff, state_in;
   logic [6:0]           count_ff;
   logic                 rev_ff, rev_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic signed [VW-1:0] xq_ff, xq_in;
   logic [NW-1:0]        i_ff, i_in, j_ff, j_in;
   logic signed [VW-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [VW-1:0] y0_ff, y0_in;
   logic [NW-1:0]        sel_ff, sel_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in, t_ff, t_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        prod_ff;
   rsp_word_type         out_ff, out_in;
   logic                 ov_ff, ov_in;
   logic                 dstart, ddone;
   logic [QW-1:0]        quot;

   // saturated point count
   logic [NW-1:0] n_used;
   always_comb begin
      if (NW'(count_ff) < NW'(2)) n_used = NW'(2);
      else if (NW'(count_ff) > NW'(MAX_POINTS)) n_used = NW'(MAX_POINTS);
      else n_used = NW'(count_ff);
   end

   function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
      mag = v[DW-1] ? DW'(-v) : v;
   endfunction

   logic signed [DW+1:0] ysum;
   always_comb begin
      // add/subtract unit: sign-extended y0 and the zero-extended QW-bit quotient
      ysum = neg_ff ? (DW+2)'(y0_ff) - (DW+2)'($signed({2'b00, quot}))
                    : (DW+2)'(y0_ff) + (DW+2)'($signed({2'b00, quot}));
   end

   always_comb begin
      state_in = state_ff; rev_in = rev_ff; cmd_in = cmd_ff; xq_in = xq_ff;
      i_in = i_ff; j_in = j_ff; ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff;
      by_in = by_ff; y0_in = y0_ff; sel_in = sel_ff; dx_in = dx_ff; dy_in = dy_ff;
      t_in = t_ff; neg_in = neg_ff; out_in = out_ff; ov_in = ov_ff;
      raddr = i_ff[AW-1:0]; we = 1'b0; waddr = i_ff[AW-1:0]; wx = ax_ff; wy = ay_ff;
      dstart = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_word.command; xq_in = req_word.x_value;
               out_in = '0;
               case (req_word.command)
                  CMD_WRITE: begin
                     if (32'(req_word.point_index) < 32'(MAX_POINTS)) begin
                        we = 1'b1;
                        waddr = AW'(req_word.point_index);
                        wx = req_word.x_value; wy = req_word.y_value;
                     end
                     state_in = S_DONE;
                  end
                  CMD_SETUP: begin
                     raddr = '0; state_in = S_SU_RD; i_in = NW'(0);
                     j_in = n_used - NW'(1); sel_in = NW'(0);
                  end
                  CMD_QUERY: begin
                     raddr = '0; state_in = S_Q_RD; i_in = NW'(0);
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            ov_in = 1'b1; state_in = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            if (!rsp_stall) begin
               ov_in = 1'b0; state_in = S_IDLE;
            end
         end
         // setup: read point 0 and point n-1, decide, then swap sweep if reversed, then order check
         S_SU_RD: begin ax_in = rx_ff; raddr = j_ff[AW-1:0]; state_in = S_SU_XC; end
         S_SU_XC: begin raddr = j_ff[AW-1:0]; state_in = S_SU_RA; end
         S_SU_RA: begin
            rev_in = ax_ff > rx_ff;
            if (ax_ff > rx_ff) begin
               raddr = i_ff[AW-1:0]; state_in = S_SU_RB;
            end else begin
               raddr = '0; i_in = NW'(0); state_in = S_CK_RD;
            end
         end
         S_SU_RB: begin raddr = j_ff[AW-1:0]; state_in = S_SU_WA; end
         S_SU_WA: begin
            ax_in = rx_ff; ay_in = ry_ff; state_in = S_SU_WB;
         end
         S_SU_WB: begin
            // swap: write j's data at i, then i's data at j
            we = 1'b1; waddr = i_ff[AW-1:0]; wx = ax_ff; wy = ay_ff;
            bx_in = rx_ff; by_in = ry_ff; state_in = S_SU_RB + 5'd0;
            state_in = S_CK_W;
         end
         S_CK_W: begin
            if (sel_ff == NW'(0)) begin
               we = 1'b1; waddr = j_ff[AW-1:0]; wx = bx_ff; wy = by_ff;
               i_in = i_ff + NW'(1); j_in = j_ff - NW'(1);
               if (i_ff + NW'(1) < j_ff - NW'(1) + NW'(0) || (i_ff + NW'(1) < j_ff
                   && i_ff + NW'(1) <= j_ff - NW'(1))) begin
                  raddr = AW'(i_ff + NW'(1)); state_in = S_SU_RB;
               end else begin
                  raddr = '0; i_in = NW'(0); sel_in = NW'(1); state_in = S_CK_RD;
               end
            end else begin
               // order check: compare previous x with current
               if (i_ff != NW'(0) && ax_ff >= rx_ff) begin
                  out_in.status = ST_INVALID; sel_in = NW'(0); state_in = S_DONE;
               end else if (i_ff == n_used - NW'(1)) begin
                  out_in.status = ST_VALID; sel_in = NW'(0); state_in = S_DONE;
               end else begin
                  ax_in = rx_ff; i_in = i_ff + NW'(1); raddr = AW'(i_ff + NW'(1));
                  state_in = S_CK_RD;
               end
            end
         end
         S_CK_RD: begin sel_in = NW'(1); state_in = S_CK_W; end
         // query: first and last endpoints, then bracket scan
         S_Q_RD: begin
            ax_in = rx_ff; ay_in = ry_ff; raddr = AW'(n_used - NW'(1));
            state_in = S_Q_FIRST;
            if (xq_ff < rx_ff) begin
               out_in.y_result = 32'(ry_ff); out_in.status = ST_CLAMP_LO;
               state_in = S_DONE;
            end
         end
         S_Q_FIRST: begin raddr = AW'(n_used - NW'(1)); state_in = S_Q_LAST; end
         S_Q_LAST: begin
            if (xq_ff > rx_ff) begin
               out_in.y_result = 32'(ry_ff); out_in.status = ST_CLAMP_HI;
               state_in = S_DONE;
            end else begin
               i_in = NW'(1); raddr = AW'(1); sel_in = n_used - NW'(2);
               state_in = S_Q_SCAN; bx_in = ax_ff;
            end
         end
         S_Q_SCAN: begin
            // bx holds x[i-1]; rx is x[i] (read issued last cycle)
            if (i_ff == NW'(0)) begin
               i_in = NW'(1); state_in = S_Q_SCAN; raddr = AW'(1);
            end else if (xq_ff >= bx_ff && xq_ff <= rx_ff) begin
               sel_in = i_ff - NW'(1); raddr = AW'(i_ff - NW'(1)); state_in = S_Q_Y0;
            end else if (i_ff == n_used - NW'(1)) begin
               raddr = AW'(sel_ff); state_in = S_Q_Y0;
            end else begin
               bx_in = rx_ff; i_in = i_ff + NW'(1); raddr = AW'(i_ff + NW'(1));
            end
         end
         S_Q_Y0: begin
            ax_in = rx_ff; y0_in = ry_ff;
            raddr = AW'(sel_ff + NW'(1)); state_in = S_Q_Y1; i_in = NW'(0);
         end
         S_Q_Y1: begin
            if (i_ff == NW'(0)) begin
               i_in = NW'(1);
               raddr = AW'(sel_ff + NW'(1));
            end else begin
               dx_in = DW'(rx_ff) - DW'(ax_ff);
               dy_in = DW'(ry_ff) - DW'(y0_ff);
               t_in  = DW'(xq_ff) - DW'(ax_ff);
               state_in = S_Q_MUL;
            end
         end
         S_Q_MUL: begin
            if (dx_ff == '0) begin
               out_in.y_result = -32'sd65536; out_in.status = ST_ZERO;
               state_in = S_DONE;
            end else begin
               neg_in = (dy_ff[DW-1] != t_ff[DW-1]) != dx_ff[DW-1];
               state_in = S_Q_DIV;
            end
         end
         S_Q_DIV: begin dstart = 1'b1; state_in = S_Q_FIN; end
         S_Q_FIN: begin
            if (ddone) begin
               if (ysum > Y_MAX)
                  out_in.y_result = 32'(Y_MAX);
               else if (ysum < Y_MIN)
                  out_in.y_result = 32'(Y_MIN);
               else out_in.y_result = 32'(ysum);
               out_in.status = ST_OK; state_in = S_DONE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_x[waddr] <= wx; mem_y[waddr] <= wy;
      end
      rx_ff <= mem_x[raddr]; ry_ff <= mem_y[raddr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mag(dy_ff)) * PW'(mag(t_ff));
      xq_ff <= xq_in; i_ff <= i_in; j_ff <= j_in; ax_ff <= ax_in; ay_ff <= ay_in;
      bx_ff <= bx_in; by_ff <= by_in; y0_ff <= y0_in; dx_ff <= dx_in; dy_ff <= dy_in;
      t_ff <= t_in; neg_ff <= neg_in; out_ff <= out_in; cmd_ff <= cmd_in;
      if (reset) begin
         state_ff <= S_IDLE; rev_ff <= 1'b0; count_ff <= 7'd2; ov_ff <= 1'b0;
         sel_ff <= '0;
      end else begin
         state_ff <= state_in; rev_ff <= rev_in; ov_ff <= ov_in; sel_ff <= sel_in;
         if (csr_write) count_ff <= csr_data;
      end
   end

   pli_divider #(.NUM_WIDTH(PW), .DEN_WIDTH(DW), .Q_WIDTH(QW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .numer(prod_ff),
      .denom(mag(dx_ff)), .cap(QW'(1) << (VW + 1)), .done(ddone), .quot(quot)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_word  = out_ff;

`ifndef SYNTHESIS
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("response pending while idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response changed under stall");
   a_div: assert property (@(posedge clock) disable iff (reset)
      dstart |-> dx_ff != '0) else $error("divide by zero span");
`endif
endmodule
